/* rtl/core/sp_dma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signal processor DMA register package
// Shared command codes, register indexes and controller/datapath interface.
// ----------------------------------------------------------------------------
package sp_dma_pkg;

  localparam int unsigned BankBytes = 4096;

  typedef enum logic [2:0] {
    CMD_REG_READ     = 3'd0,
    CMD_REG_WRITE    = 3'd1,
    CMD_TICK         = 3'd2,
    CMD_RAM_READ     = 3'd3,
    CMD_RAM_WRITE    = 3'd4,
    CMD_SCRATCH_READ = 3'd5,
    CMD_SCRATCH_WRITE = 3'd6,
    CMD_NONE         = 3'd7
  } cmd_e;

  typedef enum logic [3:0] {
    REG_MEM_ADDR  = 4'd0,
    REG_DRAM_ADDR = 4'd1,
    REG_READ_LEN  = 4'd2,
    REG_WRITE_LEN = 4'd3,
    REG_STATUS    = 4'd4,
    REG_FULL      = 4'd5,
    REG_BUSY      = 4'd6,
    REG_SEMAPHORE = 4'd7,
    REG_PC        = 4'd8
  } reg_e;

  localparam logic [3:0] CfgDoneTicks = 4'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DMA_RD,
    ST_DMA_WR,
    ST_OUT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic exec;       // perform the register/direct part of the item
    logic dma_start;  // load the DMA walker
    logic dma_dir;    // 1: scratch to RAM
    logic dma_read;   // issue source byte read
    logic dma_write;  // write destination byte and advance
    logic out_load;   // capture result
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic start_req;  // the executed item starts a transfer
    logic start_dir;
    logic dma_last;   // the current byte is the last one
    logic dma_empty;  // the transfer has no bytes
  } stat_t;

endpackage

/* rtl/core/sp_dma_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signal processor DMA controller
// Sequences one item: execute, optional byte-wise copy, then result.
// ----------------------------------------------------------------------------
module sp_dma_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic               out_free_i,
  input  sp_dma_pkg::stat_t  stat_i,
  output sp_dma_pkg::ctrl_t  ctrl_o,
  output logic               in_ready_o
);
  import sp_dma_pkg::*;

  state_e state_q, state_d;
  logic   dir_q, dir_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dir_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    dir_d      = dir_q;
    ctrl_o     = '0;
    ctrl_o.dma_dir = dir_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        ctrl_o.exec = 1'b1;
        if (stat_i.start_req) begin
          dir_d            = stat_i.start_dir;
          ctrl_o.dma_start = 1'b1;
          ctrl_o.dma_dir   = stat_i.start_dir;
          state_d          = ST_DMA_RD;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DMA_RD: begin
        if (stat_i.dma_empty) begin
          state_d = ST_OUT;
        end else begin
          ctrl_o.dma_read = 1'b1;
          state_d         = ST_DMA_WR;
        end
      end
      ST_DMA_WR: begin
        ctrl_o.dma_write = 1'b1;
        state_d = stat_i.dma_last ? ST_OUT : ST_DMA_RD;
      end
      ST_OUT: begin
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/sp_dma_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signal processor DMA datapath
// Registers, flags, tick counter, scratch and main memories, DMA walker.
// ----------------------------------------------------------------------------
module sp_dma_dp #(
  parameter int unsigned RamBytes = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic [2:0]         command_i,
  input  logic [3:0]         reg_index_i,
  input  logic [23:0]        mem_address_i,
  input  logic [31:0]        write_data_i,
  input  logic [7:0]         done_ticks_i,
  input  sp_dma_pkg::ctrl_t  ctrl_i,
  output sp_dma_pkg::stat_t  stat_o,
  output logic [31:0]        read_data_o,
  output logic               copy_busy_o,
  output logic               copy_queued_o,
  output logic               interrupt_o,
  output logic               halted_o
);
  import sp_dma_pkg::*;

  localparam int unsigned RamAw = $clog2(RamBytes);

  logic [2:0]  cmd_q;
  logic [3:0]  idx_q;
  logic [23:0] addr_q;
  logic [31:0] wdata_q;

  logic [11:0] sp_addr_q;
  logic        sp_bank_q;
  logic [23:0] ram_addr_q;
  logic [31:0] geo_sp_q, geo_ram_q;
  logic [11:0] pc_q;
  logic [4:0]  cflags_q;
  logic [7:0]  sig_q;
  logic        intr_q, sem_q;
  logic        busy_q, full_q, qdir_q;
  logic [7:0]  ticks_q;
  logic [31:0] rd_q;

  // DMA walker
  logic [11:0] w_src_q, w_row_src_q;
  logic [23:0] w_dst_q, w_row_dst_q;
  logic [11:0] w_i_q, w_len_q, w_skip_q;
  logic [7:0]  w_c_q, w_cnt_q;
  logic        w_dir_q;

  logic [7:0] scratch_mem [2*BankBytes];
  logic [7:0] ram_mem [RamBytes];
  logic [7:0] sp_rdata_q, ram_rdata_q;

  // Execute-time decisions.
  logic        is_wr, is_len, dir_new, start_now, start_tick, tick_end;
  logic [31:0] geo_sel;
  logic [7:0]  ticks_dec;
  assign is_wr   = cmd_e'(cmd_q) == CMD_REG_WRITE;
  assign is_len  = is_wr && (reg_e'(idx_q) == REG_READ_LEN || reg_e'(idx_q) == REG_WRITE_LEN);
  assign dir_new = reg_e'(idx_q) == REG_WRITE_LEN;
  assign ticks_dec = (ticks_q != 8'd0) ? ticks_q - 8'd1 : 8'd0;
  assign tick_end  = cmd_e'(cmd_q) == CMD_TICK && busy_q && ticks_dec == 8'd0;
  assign start_tick = tick_end && full_q;
  assign start_now  = is_len && !busy_q;

  assign stat_o.start_req = start_now || start_tick;
  assign stat_o.start_dir = start_now ? dir_new : qdir_q;
  assign geo_sel = stat_o.start_dir ?
                   ((start_now) ? wdata_q : geo_ram_q) :
                   ((start_now) ? wdata_q : geo_sp_q);
  assign stat_o.dma_empty = (w_len_q == 12'd0) || (w_cnt_q == 8'd0);
  assign stat_o.dma_last  = (w_i_q == w_len_q - 12'd1) && (w_c_q == w_cnt_q - 8'd1);

  // Current byte addresses.
  logic [12:0]      sp_idx;
  logic [RamAw-1:0] ram_idx;
  assign sp_idx  = {sp_bank_q, w_src_q};
  assign ram_idx = RamAw'(w_dst_q % RamBytes);

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      cmd_q   <= command_i;
      idx_q   <= reg_index_i;
      addr_q  <= mem_address_i;
      wdata_q <= write_data_i;
    end
  end

  // Memories; direct writes in EXEC, DMA copies in the write step.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && cmd_e'(cmd_q) == CMD_SCRATCH_WRITE)
      scratch_mem[addr_q[12:0]] <= wdata_q[7:0];
    else if (ctrl_i.dma_write && !w_dir_q)
      scratch_mem[sp_idx] <= ram_rdata_q;
    if (ctrl_i.exec && cmd_e'(cmd_q) == CMD_RAM_WRITE)
      ram_mem[RamAw'(addr_q % RamBytes)] <= wdata_q[7:0];
    else if (ctrl_i.dma_write && w_dir_q)
      ram_mem[ram_idx] <= sp_rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.dma_read) begin
      sp_rdata_q  <= scratch_mem[sp_idx];
      ram_rdata_q <= ram_mem[ram_idx];
    end else if (ctrl_i.exec) begin
      sp_rdata_q  <= scratch_mem[addr_q[12:0]];
      ram_rdata_q <= ram_mem[RamAw'(addr_q % RamBytes)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.dma_start) begin
      w_dir_q     <= ctrl_i.dma_dir;
      w_len_q     <= geo_sel[11:0];
      w_cnt_q     <= geo_sel[19:12];
      w_skip_q    <= geo_sel[31:20];
      w_src_q     <= sp_addr_q;
      w_row_src_q <= sp_addr_q;
      w_dst_q     <= ram_addr_q;
      w_row_dst_q <= ram_addr_q;
      w_i_q       <= '0;
      w_c_q       <= '0;
    end else if (ctrl_i.dma_write) begin
      if (w_i_q == w_len_q - 12'd1) begin
        w_i_q       <= '0;
        w_c_q       <= w_c_q + 8'd1;
        w_src_q     <= w_row_src_q + w_skip_q;
        w_row_src_q <= w_row_src_q + w_skip_q;
        w_dst_q     <= w_row_dst_q + 24'(w_skip_q);
        w_row_dst_q <= w_row_dst_q + 24'(w_skip_q);
      end else begin
        w_i_q   <= w_i_q + 12'd1;
        w_src_q <= w_src_q + 12'd1;
        w_dst_q <= w_dst_q + 24'd1;
      end
    end
  end

  // Register and flag state.
  logic [4:0] cf_n;
  logic [7:0] sig_n;
  always_comb begin
    cf_n = cflags_q;
    if (wdata_q[0]) cf_n[0] = 1'b0;
    if (wdata_q[1]) cf_n[0] = 1'b1;
    if (wdata_q[2]) cf_n[1] = 1'b0;
    if (wdata_q[5]) cf_n[2] = 1'b0;
    if (wdata_q[6]) cf_n[2] = 1'b1;
    cf_n[3] = wdata_q[7];
    cf_n[4] = wdata_q[8];
    sig_n = sig_q;
    for (int i = 0; i < 8; i++) begin
      if (wdata_q[10+2*i]) sig_n[i] = 1'b1;
      if (wdata_q[9+2*i])  sig_n[i] = 1'b0;
    end
  end

  // Register reads only; memory bytes come from the memory read registers and
  // are picked at the output.
  logic [31:0] rd_n;
  always_comb begin
    rd_n = '0;
    case (cmd_e'(cmd_q))
      CMD_REG_READ: begin
        case (reg_e'(idx_q))
          REG_MEM_ADDR:  rd_n = {19'd0, sp_bank_q, sp_addr_q};
          REG_DRAM_ADDR: rd_n = {8'd0, ram_addr_q};
          REG_READ_LEN:  rd_n = geo_sp_q;
          REG_WRITE_LEN: rd_n = geo_ram_q;
          REG_FULL:      rd_n = {31'd0, full_q};
          REG_BUSY:      rd_n = {31'd0, busy_q};
          REG_SEMAPHORE: rd_n = {31'd0, sem_q};
          REG_PC:        rd_n = {20'd0, pc_q};
          default:       rd_n = '0;
        endcase
      end
      default:          rd_n = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_addr_q  <= '0;
      sp_bank_q  <= 1'b0;
      ram_addr_q <= '0;
      geo_sp_q   <= '0;
      geo_ram_q  <= '0;
      pc_q       <= '0;
      cflags_q   <= '0;
      sig_q      <= '0;
      intr_q     <= 1'b0;
      sem_q      <= 1'b0;
      busy_q     <= 1'b0;
      full_q     <= 1'b0;
      qdir_q     <= 1'b0;
      ticks_q    <= '0;
      rd_q       <= '0;
    end else begin
      if (ctrl_i.exec) begin
        if (is_wr) begin
          case (reg_e'(idx_q))
            REG_MEM_ADDR: begin
              sp_addr_q <= wdata_q[11:0];
              sp_bank_q <= wdata_q[12];
            end
            REG_DRAM_ADDR: ram_addr_q <= wdata_q[23:0];
            REG_READ_LEN:  geo_sp_q <= wdata_q;
            REG_WRITE_LEN: geo_ram_q <= wdata_q;
            REG_STATUS: begin
              cflags_q <= cf_n;
              sig_q    <= sig_n;
              if (wdata_q[3]) intr_q <= 1'b0;
              if (wdata_q[4]) intr_q <= 1'b1;
            end
            REG_SEMAPHORE: sem_q <= 1'b0;
            REG_PC:        pc_q <= wdata_q[11:0];
            default: ;
          endcase
          if (is_len && busy_q && !full_q) begin
            full_q <= 1'b1;
            qdir_q <= dir_new;
          end
        end
        if (cmd_e'(cmd_q) == CMD_REG_READ && reg_e'(idx_q) == REG_SEMAPHORE) sem_q <= 1'b1;
        if (cmd_e'(cmd_q) == CMD_TICK && busy_q) begin
          ticks_q <= ticks_dec;
          if (tick_end) begin
            busy_q <= 1'b0;
            full_q <= 1'b0;
            qdir_q <= 1'b0;
          end
        end
        if (stat_o.start_req) begin
          busy_q  <= 1'b1;
          ticks_q <= (done_ticks_i != 8'd0) ? done_ticks_i : 8'd1;
        end
        rd_q <= rd_n;
      end
    end
  end

  assign read_data_o = (cmd_e'(cmd_q) == CMD_RAM_READ)     ? {24'd0, ram_rdata_q} :
                       (cmd_e'(cmd_q) == CMD_SCRATCH_READ) ? {24'd0, sp_rdata_q}  :
                       rd_q;
  assign copy_busy_o   = busy_q;
  assign copy_queued_o = full_q;
  assign interrupt_o   = intr_q;
  assign halted_o      = cflags_q[0];

endmodule

/* rtl/core/signal_processor_dma_registers.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signal processor DMA registers
// Coprocessor register block with a strided byte copy engine.
// ----------------------------------------------------------------------------
// Each input transfer on s_axis carries one command: a register read or
// write, a tick, or a direct byte access to main RAM or scratch memory.
// Every command produces exactly one result transfer on m_axis with the
// read value and the busy, full, interrupt and halt levels after it.
// One item at a time is handled: execute after the input transfer, then
// for a transfer-starting item a read step and a write step per copied
// byte (len * count bytes, bounded by the single port of each memory),
// or a single read step when the started copy has no bytes, then the
// result state. The result is registered when the block leaves the result
// state, and the next input is accepted only after that. The output
// register holds the result while m_axis_tready is low; the block waits
// in the result state while a previous result is still held.
// Reset clears the register and flag state and sets dma_done_ticks to 20;
// memory contents are undefined until written. The APB port writes
// dma_done_ticks at address 0 and must be used only while idle.
// ----------------------------------------------------------------------------
module signal_processor_dma_registers #(
  parameter int unsigned RAM_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] command, [6:3] reg_index, [30:7] mem_address, [62:31] write_data
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tready,
  output logic        m_axis_tvalid,
  // [31:0] read_data, [32] copy busy, [33] copy queued, [34] interrupt_line,
  // [35] halted
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sp_dma_pkg::*;

  logic [7:0] done_ticks_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_ticks_q <= 8'd20;
    else if (psel && penable && pwrite && paddr == {CfgDoneTicks[1:0]})
      done_ticks_q <= pwdata[7:0];
  end
  assign prdata = (paddr == CfgDoneTicks[1:0]) ? {24'd0, done_ticks_q} : 32'd0;

  ctrl_t ctrl;
  stat_t stat;
  logic  in_fire, out_valid_q;
  logic [31:0] rd;
  logic busy, full, intr, halt;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  sp_dma_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i (in_fire),
    .out_free_i(!out_valid_q || m_axis_tready),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .in_ready_o(s_axis_tready)
  );

  sp_dma_dp #(.RamBytes(RAM_BYTES)) u_dp (
    .clk_i, .rst_ni,
    .in_fire_i    (in_fire),
    .command_i    (s_axis_tdata[2:0]),
    .reg_index_i  (s_axis_tdata[6:3]),
    .mem_address_i(s_axis_tdata[30:7]),
    .write_data_i (s_axis_tdata[62:31]),
    .done_ticks_i (done_ticks_q),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .read_data_o  (rd),
    .copy_busy_o  (busy),
    .copy_queued_o(full),
    .interrupt_o  (intr),
    .halted_o     (halt)
  );

  // Result register; loaded when the controller leaves the result state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (ctrl.out_load) out_valid_q <= 1'b1;
    else if (m_axis_tready) out_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) m_axis_tdata <= {4'd0, halt, intr, full, busy, rd};
  end
  assign m_axis_tvalid = out_valid_q;

  // Full never stands without busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> busy)
    else $error("queued transfer without busy");
  // A result is loaded only from the result state, never while one is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!out_valid_q || m_axis_tready))
    else $error("result overwritten");
  // No input is taken while a copy runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.dma_read || ctrl.dma_write) |-> !s_axis_tready)
    else $error("input accepted during copy");

endmodule
